// ----- design/gb2d_pkg.sv -----
// Package: shared types and constants for the Gaussian blur block.
`timescale 1ns / 1ps
package gb2d_pkg;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RUN,
    S_WAIT1,
    S_WAIT2,
    S_DONE
  } state_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_RADIUS   = 3'd0;
  localparam logic [2:0] REG_WEIGHT_0 = 3'd1;
  localparam logic [2:0] REG_WEIGHT_1 = 3'd2;
  localparam logic [2:0] REG_WEIGHT_2 = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_COLOR    = 3'd6;

  localparam int PIX_W  = 24;  // packed pixel
  localparam int WT_W   = 32;  // Q0.32 2D tap weight
  localparam int PROD_W = 40;  // 8 x 32 product
  localparam int ACC_W  = 46;  // sum of up to 25 products
  localparam int POS_W  = 15;  // signed row / column position

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;  // zero the accumulators
    logic vld;    // read data and tap weight are valid this cycle
  } mac_ctrl_t;

endpackage

// ----- design/gb2d_line_mem.sv -----
// Line store: simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module gb2d_line_mem #(
  parameter int AW = 13,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/gb2d_mac.sv -----
// Multiply-accumulate unit: three channel products, accumulation, rounding.
`timescale 1ns / 1ps
module gb2d_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gb2d_pkg::mac_ctrl_t        ctrl,
  input  logic [gb2d_pkg::PIX_W-1:0] pix,
  input  logic [gb2d_pkg::WT_W-1:0]  wt,
  output logic [2:0][7:0]            res
);
  import gb2d_pkg::*;

  localparam logic [ACC_W:0] RND = (ACC_W+1)'(64'h8000_0000);

  logic [2:0][PROD_W-1:0] prod_r;
  logic                   prod_v_r;
  logic [2:0][ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= PROD_W'(pix[8*c +: 8]) * PROD_W'(wt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (ctrl.clear) begin
        acc_r[c] <= '0;
      end else if (prod_v_r) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
  end

  // Round half up, then saturate.
  always_comb begin
    logic [ACC_W:0]    rsum;
    logic [ACC_W-32:0] v;
    for (int c = 0; c < 3; c++) begin
      rsum   = {1'b0, acc_r[c]} + RND;
      v      = rsum[ACC_W:32];
      res[c] = (v > (ACC_W-31)'(255)) ? 8'hFF : v[7:0];
    end
  end

endmodule

// ----- design/gaussian_blur_2d_mirror_border_top.sv -----
// Top level: Gaussian blur with mirrored borders over a ring of line buffers.
// Flow: an input that releases an output walks the window in S_RUN, then S_WAIT1,
//   S_WAIT2 and S_DONE load the result register; one that releases none returns via
//   S_DECIDE to S_IDLE. Input is taken only in S_IDLE; the single read port of the line
//   store delivers one window tap per cycle.
// Reset: synchronous active low; counters, sequencer and registers to defaults only.
`timescale 1ns / 1ps
module gaussian_blur_2d_mirror_border_top #(
  parameter int MAX_RADIUS = 2,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_r,
  input  logic [7:0]  in_pixel_g,
  input  logic [7:0]  in_pixel_b,
  input  logic        in_drain,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_r,
  output logic [7:0]  out_g,
  output logic [7:0]  out_b,
  output logic        out_frame_end
);
  import gb2d_pkg::*;

  localparam int RING = 2 * MAX_RADIUS + 2;      // rows held in the ring
  localparam int RW   = $clog2(RING);            // ring index bits
  localparam int CW   = $clog2(MAX_WIDTH);       // column bits
  localparam int WW   = CW + 1;                  // width value bits
  localparam int AW   = RW + CW;                 // line store address bits
  localparam int OW   = $clog2(MAX_RADIUS + 1) + 1;  // signed tap offset bits
  localparam int RSW  = RW + 2;                  // signed ring sum bits

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]  radius_r;
  logic [15:0] weight_r [3];
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic        color_r;
  logic        cfg_restart;

  // Geometry writes restart the frame.
  assign cfg_restart = cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH
                                  || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= 2'd1;
      weight_r[0] <= 16'd29615;
      weight_r[1] <= 16'd17961;
      weight_r[2] <= 16'd0;
      width_r     <= 11'd640;
      height_r    <= 13'd480;
      color_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:   radius_r    <= cfg_data[1:0];
        REG_WEIGHT_0: weight_r[0] <= cfg_data;
        REG_WEIGHT_1: weight_r[1] <= cfg_data;
        REG_WEIGHT_2: weight_r[2] <= cfg_data;
        REG_WIDTH:    width_r     <= cfg_data[10:0];
        REG_HEIGHT:   height_r    <= cfg_data[12:0];
        REG_COLOR:    color_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, large values saturate.
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [1:0]    r_eff;
  logic signed [OW-1:0] r_s;

  always_comb begin
    if (width_r == 11'd0) begin
      w_eff = WW'(1);
    end else if (14'(width_r) > 14'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == 13'd0) begin
      h_eff = 13'd1;
    end else if (height_r > 13'd4096) begin
      h_eff = 13'd4096;
    end else begin
      h_eff = height_r;
    end
    r_eff = (radius_r > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : radius_r;
    r_s   = signed'(OW'(r_eff));
  end

  // ---------------------------------------------------------------------------
  // Frame position counters
  // ---------------------------------------------------------------------------
  logic [CW-1:0] in_column_r;
  logic [11:0]   in_row_r;
  logic [RW-1:0] in_ring_r;
  logic          in_done_r;
  logic [CW-1:0] out_column_r;
  logic [11:0]   out_row_r;
  logic [RW-1:0] out_ring_r;

  state_t state_r, state_nxt;

  logic in_accept;
  logic pix_we;
  logic ready;
  logic last_tap;
  logic load_out;
  logic frame_last;
  logic out_col_wrap;
  logic in_col_wrap;
  logic in_row_wrap;
  mac_ctrl_t mac_ctrl;

  assign in_accept = in_valid && !in_stall;
  // A pixel after the whole frame arrived is dropped and acts as a drain.
  assign pix_we    = in_accept && !in_drain && !in_done_r;

  assign in_col_wrap  = WW'(in_column_r) + WW'(1) >= w_eff;
  assign in_row_wrap  = 13'(in_row_r) + 13'd1 >= h_eff;
  assign out_col_wrap = WW'(out_column_r) + WW'(1) >= w_eff;
  assign frame_last   = out_col_wrap && (13'(out_row_r) + 13'd1 >= h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart || (load_out && frame_last)) begin
      in_column_r  <= '0;
      in_row_r     <= '0;
      in_ring_r    <= '0;
      in_done_r    <= 1'b0;
      out_column_r <= '0;
      out_row_r    <= '0;
      out_ring_r   <= '0;
    end else begin
      if (pix_we) begin
        if (in_col_wrap) begin
          in_column_r <= '0;
          in_ring_r   <= (in_ring_r == RW'(RING - 1)) ? '0 : in_ring_r + RW'(1);
          if (in_row_wrap) begin
            in_row_r  <= '0;
            in_done_r <= 1'b1;
          end else begin
            in_row_r  <= in_row_r + 12'd1;
          end
        end else begin
          in_column_r <= in_column_r + CW'(1);
        end
      end
      if (load_out) begin
        if (out_col_wrap) begin
          out_column_r <= '0;
          out_row_r    <= out_row_r + 12'd1;
          out_ring_r   <= (out_ring_r == RW'(RING - 1)) ? '0 : out_ring_r + RW'(1);
        end else begin
          out_column_r <= out_column_r + CW'(1);
        end
      end
    end
  end

  // Output pixel is ready once the bottom-right pixel of its window has arrived.
  always_comb begin
    logic [12:0]   nr_sum;
    logic [11:0]   need_row;
    logic [WW-1:0] nc_sum;
    logic [CW-1:0] need_col;
    nr_sum   = 13'(out_row_r) + 13'(r_eff);
    need_row = (nr_sum < h_eff) ? nr_sum[11:0] : 12'(h_eff - 13'd1);
    nc_sum   = WW'(out_column_r) + WW'(r_eff);
    need_col = (nc_sum < w_eff) ? nc_sum[CW-1:0] : CW'(w_eff - WW'(1));
    ready    = in_done_r || (in_row_r > need_row)
               || (in_row_r == need_row && in_column_r > need_col);
  end

  // ---------------------------------------------------------------------------
  // Tap sequencer: walk the window one tap per cycle
  // ---------------------------------------------------------------------------
  logic signed [OW-1:0] ti_r, tj_r;

  assign last_tap = (ti_r == r_s) && (tj_r == r_s);

  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE) begin
      ti_r <= -r_s;
      tj_r <= -r_s;
    end else if (state_r == S_RUN) begin
      if (tj_r == r_s) begin
        tj_r <= -r_s;
        ti_r <= ti_r + OW'(1);
      end else begin
        tj_r <= tj_r + OW'(1);
      end
    end
  end

  function automatic logic signed [POS_W-1:0] mirror(
    input logic signed [POS_W-1:0] pos,
    input logic signed [POS_W-1:0] off,
    input logic signed [POS_W-1:0] size
  );
    logic signed [POS_W-1:0] p;
    logic signed [POS_W-1:0] m;
    p = pos + off;
    m = pos - off;
    if (p < 0) begin
      p = (m < size) ? m : '0;
    end
    if (p >= size) begin
      p = (m >= 0) ? m : size - POS_W'(1);
    end
    return p;
  endfunction

  function automatic logic [15:0] pick_weight(input logic [1:0] idx,
                                              input logic [15:0] w0,
                                              input logic [15:0] w1,
                                              input logic [15:0] w2);
    logic [15:0] w;
    case (idx)
      2'd0:    w = w0;
      2'd1:    w = w1;
      2'd2:    w = w2;
      default: w = '0;
    endcase
    return w;
  endfunction

  logic [AW-1:0]   rd_addr;
  logic [WT_W-1:0] wt_r;
  logic [15:0]     wi, wj;

  always_comb begin
    logic signed [POS_W-1:0] pos_row;
    logic signed [POS_W-1:0] pos_col;
    logic signed [POS_W-1:0] ro;
    logic signed [POS_W-1:0] co;
    logic signed [RSW-1:0]   rsum;
    logic [RW-1:0]           ring;
    logic [OW-1:0]           ai, aj;
    pos_row = signed'(POS_W'(out_row_r));
    pos_col = signed'(POS_W'(out_column_r));
    ro      = mirror(pos_row, POS_W'(ti_r), signed'(POS_W'(h_eff)));
    co      = mirror(pos_col, POS_W'(tj_r), signed'(POS_W'(w_eff)));
    // Mirrored row stays within the radius of the output row: fold into ring.
    rsum    = signed'(RSW'(out_ring_r)) + RSW'(ro - pos_row);
    if (rsum < 0) begin
      rsum = rsum + RSW'(RING);
    end else if (rsum >= RSW'(RING)) begin
      rsum = rsum - RSW'(RING);
    end
    ring    = rsum[RW-1:0];
    rd_addr = {ring, co[CW-1:0]};
    ai      = (ti_r < 0) ? -ti_r : ti_r;
    aj      = (tj_r < 0) ? -tj_r : tj_r;
    wi      = pick_weight(2'(ai), weight_r[0], weight_r[1], weight_r[2]);
    wj      = pick_weight(2'(aj), weight_r[0], weight_r[1], weight_r[2]);
  end

  // Tap weight is registered so that it lines up with the registered read data.
  always_ff @(posedge clk) begin
    wt_r <= WT_W'(wi) * WT_W'(wj);
  end

  logic             issue_r;
  logic [PIX_W-1:0] rd_data;
  logic [2:0][7:0]  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
    end else begin
      issue_r <= (state_r == S_RUN);
    end
  end

  gb2d_line_mem #(
    .AW (AW),
    .DW (PIX_W)
  ) u_line_mem (
    .clk   (clk),
    .we    (pix_we),
    .waddr ({in_ring_r, in_column_r}),
    .wdata ({in_pixel_b, in_pixel_g, in_pixel_r}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign mac_ctrl.clear = (state_r == S_DECIDE) && ready;
  assign mac_ctrl.vld   = issue_r;

  gb2d_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .pix   (rd_data),
    .wt    (wt_r),
    .res   (res)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_accept) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = ready ? S_RUN : S_IDLE;
      S_RUN:    if (last_tap) state_nxt = S_WAIT1;
      S_WAIT1:  state_nxt = S_WAIT2;
      S_WAIT2:  state_nxt = S_DONE;
      S_DONE:   if (load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != S_IDLE);
    load_out = (state_r == S_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the transaction until the sink takes it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r         <= res[0];
      out_g         <= color_r ? res[1] : 8'd0;
      out_b         <= color_r ? res[2] : 8'd0;
      out_frame_end <= frame_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (ti_r <= r_s && ti_r >= -r_s && tj_r <= r_s && tj_r >= -r_s))
    else $error("tap offset outside the window");

  a_done_counters: assert property (@(posedge clk) disable iff (!rst_n)
    in_done_r |-> (in_row_r == 12'd0 && in_column_r == '0))
    else $error("input counters not cleared at frame input end");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid && out_stall) |=> (state_r == S_DONE))
    else $error("result left the sequencer while the output was stalled");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pix_we |-> (state_r == S_IDLE && !in_done_r))
    else $error("line store written outside an input transaction");
`endif

endmodule

// ----- bench/gb2d_blur_checker.sv -----
// Checker: predicts blurred pixels from the observed traffic and compares them.
`timescale 1ns / 1ps
module gb2d_blur_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_pixel_r,
  input  logic [7:0]  in_pixel_g,
  input  logic [7:0]  in_pixel_b,
  input  logic        in_drain,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_r,
  input  logic [7:0]  out_g,
  input  logic [7:0]  out_b,
  input  logic        out_frame_end,
  output int          fail_count,
  output int          pending,
  output int          frames_done
);
  import gb2d_pkg::*;

  localparam int RING = 6;
  localparam int LINE = 1024;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fend;
  } blur_px_t;

  blur_px_t   blurred_q[$];
  logic [23:0] rows_mem[RING*LINE];

  logic [1:0]  k_radius;
  logic [15:0] k_wt[3];
  logic [10:0] k_width;
  logic [12:0] k_height;
  logic        k_color;
  int unsigned ic, ir, oc, orow;
  bit          in_full;

  function automatic int reflect(int pos, int off, int size);
    int p;
    p = pos + off;
    if (p < 0) p = (pos - off < size) ? pos - off : 0;
    if (p >= size) p = (pos - off >= 0) ? pos - off : size - 1;
    return p;
  endfunction

  task automatic restart();
    ic = 0; ir = 0; oc = 0; orow = 0; in_full = 0;
  endtask

  task automatic blur_step(logic [7:0] pr, logic [7:0] pg, logic [7:0] pb, logic dr);
    int unsigned w, h, rr, recv, nr, nc;
    int ro, co;
    logic [63:0] acc[3];
    logic [63:0] wt, v;
    logic [23:0] px;
    blur_px_t e;
    w = (k_width == 0) ? 1 : ((k_width > LINE) ? LINE : k_width);
    h = (k_height == 0) ? 1 : ((k_height > 4096) ? 4096 : k_height);
    rr = (k_radius > 2) ? 2 : k_radius;
    if (!dr && !in_full) begin
      rows_mem[(ir % RING) * LINE + ic] = {pb, pg, pr};
      ic++;
      if (ic >= w) begin
        ic = 0; ir++;
        if (ir >= h) begin
          ir = 0; in_full = 1;
        end
      end
    end
    recv = in_full ? w * h : ir * w + ic;
    nr = (orow + rr < h) ? orow + rr : h - 1;
    nc = (oc + rr < w) ? oc + rr : w - 1;
    if (recv <= nr * w + nc) return;
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int i = -int'(rr); i <= int'(rr); i++) begin
      ro = reflect(orow, i, h);
      for (int j = -int'(rr); j <= int'(rr); j++) begin
        co = reflect(oc, j, w);
        wt = 64'(k_wt[i < 0 ? -i : i]) * 64'(k_wt[j < 0 ? -j : j]);
        px = rows_mem[(ro % RING) * LINE + co];
        for (int c = 0; c < 3; c++) acc[c] += 64'(px[8*c +: 8]) * wt;
      end
    end
    v = (acc[0] + 64'h8000_0000) >> 32; e.r = (v > 255) ? 8'd255 : v[7:0];
    v = (acc[1] + 64'h8000_0000) >> 32; e.g = (v > 255) ? 8'd255 : v[7:0];
    v = (acc[2] + 64'h8000_0000) >> 32; e.b = (v > 255) ? 8'd255 : v[7:0];
    if (!k_color) begin
      e.g = 0; e.b = 0;
    end
    e.fend = 0;
    oc++;
    if (oc >= w) begin
      oc = 0; orow++;
      if (orow >= h) begin
        e.fend = 1;
        restart();
      end
    end
    blurred_q.insert(blurred_q.size(), e);
  endtask

  always @(posedge clk) begin
    blur_px_t e;
    if (!rst_n) begin
      blurred_q.delete();
      k_radius = 1; k_wt[0] = 29615; k_wt[1] = 17961; k_wt[2] = 0;
      k_width = 640; k_height = 480; k_color = 1;
      restart();
      fail_count <= 0;
      frames_done <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (out_frame_end) frames_done <= frames_done + 1;
        if (blurred_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected output r=%0d g=%0d b=%0d fe=%0b",
                     out_r, out_g, out_b, out_frame_end);
          fail_count <= fail_count + 1;
        end else begin
          e = blurred_q.pop_front();
          if (e != {out_r, out_g, out_b, out_frame_end}) begin
            if (fail_count < 10)
              $display("mismatch exp r=%0d g=%0d b=%0d fe=%0b got r=%0d g=%0d b=%0d fe=%0b",
                       e.r, e.g, e.b, e.fend, out_r, out_g, out_b, out_frame_end);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS:   begin k_radius = cfg_data[1:0]; restart(); end
          REG_WEIGHT_0: k_wt[0] = cfg_data;
          REG_WEIGHT_1: k_wt[1] = cfg_data;
          REG_WEIGHT_2: k_wt[2] = cfg_data;
          REG_WIDTH:    begin k_width = cfg_data[10:0]; restart(); end
          REG_HEIGHT:   begin k_height = cfg_data[12:0]; restart(); end
          REG_COLOR:    k_color = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) blur_step(in_pixel_r, in_pixel_g, in_pixel_b, in_drain);
    end
    pending <= blurred_q.size();
  end

endmodule

// ----- bench/tb_gaussian_blur_2d_mirror_border_top.sv -----
// Testbench top: frame stimulus, flow control and verdict for the blur block.
`timescale 1ns / 1ps
module tb_gaussian_blur_2d_mirror_border_top;
  import gb2d_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid, in_stall;
  logic [7:0]  in_pixel_r, in_pixel_g, in_pixel_b;
  logic        in_drain;
  logic        out_valid, out_stall;
  logic [7:0]  out_r, out_g, out_b;
  logic        out_frame_end;
  int          fail_count, pending, frames_done;

  int send_idle_pct;   // chance per cycle that the sender idles
  int recv_idle_pct;   // chance per cycle that the receiver stalls
  logic hold_req;
  int   hold_left;
  int   items_sent;
  int   frames_run;
  int   cycles = 0;

  gaussian_blur_2d_mirror_border_top uut (.*);

  gb2d_blur_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run well past the slowest legal completion.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("FAIL gaussian_blur_2d_mirror_border_top");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off once requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_stall <= 1;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Drive one transaction; idle beforehand at the current sender rate.
  task automatic push_item(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic dr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid   <= 1;
    in_pixel_r <= r;
    in_pixel_g <= g;
    in_pixel_b <= b;
    in_drain   <= dr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic random_pixel();
    push_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
  endtask

  // Let the block go quiet: drop valid, wait out results and the pipeline.
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic setup_frame(int rad, int wd, int ht, int w0, int w1, int w2, int mode);
    settle();
    write_reg(REG_WEIGHT_0, 16'(w0));
    write_reg(REG_WEIGHT_1, 16'(w1));
    write_reg(REG_WEIGHT_2, 16'(w2));
    write_reg(REG_COLOR, 16'(mode));
    write_reg(REG_RADIUS, 16'(rad));
    write_reg(REG_WIDTH, 16'(wd));
    write_reg(REG_HEIGHT, 16'(ht));
  endtask

  // Flush the held rows with drain transactions until the frame closes.
  task automatic finish_frame(int f0);
    while (frames_done == f0) push_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    frames_run++;
  endtask

  // Stream one frame of random pixels; optionally sprinkle drains and
  // a dropped pixel after the last input.
  task automatic run_frame(int npix, bit noise, bit extra_px);
    int f0;
    f0 = frames_done;
    for (int k = 0; k < npix; k++) begin
      if (noise && $urandom_range(9) == 0)
        push_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      random_pixel();
    end
    if (extra_px) random_pixel();
    finish_frame(f0);
  endtask

  initial begin
    int rad, wd, ht, eff_w, eff_h, mode, f0;
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_pixel_r = 0; in_pixel_g = 0; in_pixel_b = 0; in_drain = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_req = 0; items_sent = 0; frames_run = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes of pixel values in a 3x3 frame at reset weights.
    setup_frame(1, 3, 3, 29615, 17961, 0, 1);
    f0 = frames_done;
    push_item(8'd0, 8'd255, 8'd0, 1'b0);
    push_item(8'd255, 8'd0, 8'd255, 1'b0);
    push_item(8'd1, 8'd254, 8'd128, 1'b1);   // drain inside the frame
    for (int k = 0; k < 6; k++) push_item(8'd255, 8'd255, 8'd255, 1'b0);
    push_item(8'd0, 8'd0, 8'd0, 1'b0);
    push_item(8'd77, 8'd77, 8'd77, 1'b0);    // dropped: frame input complete
    finish_frame(f0);
    push_item(8'd5, 8'd5, 8'd5, 1'b1);       // drain with nothing ready

    // Full-scale weights saturate; zero weights give black; mono mode.
    setup_frame(2, 4, 3, 65535, 65535, 65535, 1);
    run_frame(12, 0, 1);
    setup_frame(1, 2, 2, 0, 0, 0, 0);
    run_frame(4, 0, 0);
    // Zero sizes act as one pixel; radius 3 saturates to 2.
    setup_frame(3, 0, 0, 40000, 12000, 800, 0);
    run_frame(1, 0, 0);

    // Hold the receiver while the sender keeps offering, so the block backs up.
    setup_frame(1, 6, 4, 29615, 17961, 0, 1);
    hold_req <= 1;
    @(posedge clk);
    hold_req <= 0;
    run_frame(24, 0, 0);

    // Pause the sender mid-frame until every expected pixel has come out.
    setup_frame(2, 5, 5, 20000, 15000, 7000, 1);
    f0 = frames_done;
    for (int k = 0; k < 12; k++) random_pixel();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int k = 0; k < 13; k++) random_pixel();
    finish_frame(f0);

    // Oversized width and height: stream part of a frame, then restart it
    // with the next geometry write.
    setup_frame(2, 2047, 1, 30000, 12000, 5000, 1);
    for (int k = 0; k < 60; k++) random_pixel();
    setup_frame(0, 1, 8191, 65535, 0, 0, 0);
    for (int k = 0; k < 20; k++) random_pixel();

    // Random frames, rotating through the flow-control phases.
    while (items_sent < 650) begin
      case (frames_run % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 77; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 77; end
        default: begin send_idle_pct = 31; recv_idle_pct = 31; end
      endcase
      rad  = $urandom_range(3);
      wd   = $urandom_range(1, 9);
      ht   = $urandom_range(1, 7);
      mode = $urandom_range(1);
      eff_w = wd;
      eff_h = ht;
      if ($urandom_range(7) == 0) begin
        setup_frame(rad, wd, ht, $urandom, $urandom, $urandom, mode);
      end else begin
        setup_frame(rad, wd, ht, $urandom_range(20000, 40000),
                    $urandom_range(8000, 20000), $urandom_range(6000), mode);
      end
      run_frame(eff_w * eff_h, 1, (rad != 0) && (eff_w > 1) && $urandom_range(1));
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle();
    $display("Covered %0d frames and %0d input transactions: radius 0..3, widths 1..2047,",
             frames_run, items_sent);
    $display("mono and color, drains, dropped pixels, back-pressure and idle phases.");
    if (fail_count == 0) begin
      $display("PASS gaussian_blur_2d_mirror_border_top");
    end else begin
      $display("FAIL gaussian_blur_2d_mirror_border_top");
    end
    $finish;
  end

endmodule

// ----- gaussian_blur_2d_mirror_border_top.f -----
design/gb2d_pkg.sv
design/gb2d_line_mem.sv
design/gb2d_mac.sv
design/gaussian_blur_2d_mirror_border_top.sv
bench/gb2d_blur_checker.sv
bench/tb_gaussian_blur_2d_mirror_border_top.sv
